/* sv/mct_pkg.sv */
// Shared types, register codes and masks for the match/capture timer.
`default_nettype none

package mct_pkg;

    // Channel counts and counter width
    localparam int NUM_MATCH   = 4;
    localparam int NUM_CAPTURE = 2;
    localparam int COUNT_WIDTH = 32;

    // Bus data width and configuration port index width
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Register field masks, limited to the channels that exist
    localparam logic [5:0]  FLAG_MASK = 6'(((1 << NUM_MATCH) - 1) |
                                           (((1 << NUM_CAPTURE) - 1) << 4));
    localparam logic [11:0] MCR_MASK  = 12'((1 << (NUM_MATCH * 3)) - 1);
    localparam logic [11:0] EMR_MASK  = 12'(((1 << NUM_MATCH) - 1) |
                                            (((1 << (NUM_MATCH * 2)) - 1) << 4));
    localparam logic [3:0]  PIN_MASK  = 4'((1 << NUM_MATCH) - 1);

    // Transaction kinds
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } mct_op_t;

    // Bus register indexes
    localparam logic [3:0] REG_IR     = 4'd0;
    localparam logic [3:0] REG_TCR    = 4'd1;
    localparam logic [3:0] REG_TC     = 4'd2;
    localparam logic [3:0] REG_PC     = 4'd3;
    localparam logic [3:0] REG_MCR    = 4'd4;
    localparam logic [3:0] REG_MATCH0 = 4'd5;
    localparam logic [3:0] REG_CAP0   = 4'd9;
    localparam logic [3:0] REG_EMR    = 4'd11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_INPUT = 2'd2;

    // Count modes
    localparam logic [1:0] MODE_TIMER = 2'd0;
    localparam logic [1:0] MODE_RISE  = 2'd1;
    localparam logic [1:0] MODE_FALL  = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    // External match actions
    localparam logic [1:0] EM_NONE   = 2'd0;
    localparam logic [1:0] EM_CLEAR  = 2'd1;
    localparam logic [1:0] EM_SET    = 2'd2;
    localparam logic [1:0] EM_TOGGLE = 2'd3;

    // One bus or tick transaction
    typedef struct packed {
        mct_op_t         opcode;
        logic [3:0]      reg_index;
        logic [DATA_W-1:0] write_data;
        logic [1:0]      capture_pins;
    } mct_item_t;

    // One result
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic [3:0]        match_pins;
    } mct_result_t;

endpackage

`default_nettype wire

/* sv/match_capture_timer.sv */
// Top level of the match/capture timer: stream ports, input and result registers.
//
// The timer takes one transaction per clock while results are taken (a tick,
// a register write or a register read) and returns exactly one result for
// each, in order. A transaction lands in the input register; the timer state
// is updated and the result computed as it moves on to the result register,
// which presents it on m_tdata. With m_tready held high the block sustains one
// transaction every cycle; a stalled result holds the input register, and
// s_tready drops only when both are full. Configuration writes (cfg_*) are
// always ready and must be issued only while no transaction is in flight.
`default_nettype none

module match_capture_timer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [mct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mct_pkg::DATA_W-1:0]    cfg_data,
    // Transaction input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // reg_index[3:0], write_data[35:4],
                                        // capture_pins[37:36], zero[39:38]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // read_data[31:0], irq[32],
                                        // match_pins[36:33], zero[39:37]
);
    import mct_pkg::*;

    logic        in_valid_reg;
    mct_item_t   in_item_reg;
    logic        out_valid_reg;
    mct_result_t out_result_reg;
    mct_result_t core_result;
    logic        advance;
    logic        s_accept;

    // Move a transaction into the result register when it has room
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.opcode       <= mct_op_t'(s_tuser);
            in_item_reg.reg_index    <= s_tdata[3:0];
            in_item_reg.write_data   <= s_tdata[35:4];
            in_item_reg.capture_pins <= s_tdata[37:36];
        end
    end

    // Timer state and per-transaction update
    mct_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (in_item_reg),
        .result    (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.match_pins, out_result_reg.irq,
                       out_result_reg.read_data};

endmodule

`default_nettype wire

/* sv/mct_core.sv */
// Timer state, register file and the per-transaction state update.
`default_nettype none

module mct_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mct_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                          step_en,
    input  wire mct_pkg::mct_item_t            item,
    output mct_pkg::mct_result_t               result
);
    import mct_pkg::*;

    // Configuration registers
    logic [DATA_W-1:0] prescale_reg;
    logic [1:0]        count_mode_reg;
    logic              count_input_reg;

    // Timer state
    logic [COUNT_WIDTH-1:0] count_reg,    count_next;
    logic [DATA_W-1:0]      pscount_reg,  pscount_next;
    logic                   run_reg,      run_next;
    logic [5:0]             flags_reg,    flags_next;
    logic [11:0]            mcr_reg,      mcr_next;
    logic [11:0]            emr_reg,      emr_next;
    logic [1:0]             pins_reg,     pins_next;
    logic [DATA_W-1:0]      match_reg   [NUM_MATCH];
    logic [DATA_W-1:0]      match_next  [NUM_MATCH];
    logic [DATA_W-1:0]      capture_reg [NUM_CAPTURE];
    logic [DATA_W-1:0]      capture_next[NUM_CAPTURE];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg    <= '0;
            count_mode_reg  <= MODE_TIMER;
            count_input_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRESCALE:    prescale_reg    <= cfg_data;
                CFG_COUNT_MODE:  count_mode_reg  <= cfg_data[1:0];
                CFG_COUNT_INPUT: count_input_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Next state and result for the current transaction
    always_comb
    begin
        logic                   advance;
        logic                   prev_lvl;
        logic                   cur_lvl;
        logic                   rise;
        logic                   fall;
        logic                   do_reset;
        logic                   do_stop;
        logic [COUNT_WIDTH-1:0] count_inc;
        logic [2:0]             ctl;
        logic [1:0]             act;

        count_next   = count_reg;
        pscount_next = pscount_reg;
        run_next     = run_reg;
        flags_next   = flags_reg;
        mcr_next     = mcr_reg;
        emr_next     = emr_reg;
        pins_next    = pins_reg;
        match_next   = match_reg;
        capture_next = capture_reg;
        result       = '0;
        advance      = 1'b0;
        do_reset     = 1'b0;
        do_stop      = 1'b0;
        prev_lvl     = pins_reg[count_input_reg];
        cur_lvl      = item.capture_pins[count_input_reg];
        rise         = !prev_lvl && cur_lvl;
        fall         = prev_lvl && !cur_lvl;
        count_inc    = count_reg + 1'b1;
        ctl          = '0;
        act          = EM_NONE;

        case (item.opcode)
            OP_TICK:
            begin
                // Prescaler in timer mode, edge detect in counter mode
                if (run_reg)
                begin
                    if (count_mode_reg == MODE_TIMER)
                    begin
                        if (pscount_reg == prescale_reg)
                        begin
                            pscount_next = '0;
                            advance      = 1'b1;
                        end
                        else
                        begin
                            pscount_next = pscount_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        advance = (count_mode_reg == MODE_RISE && rise) ||
                                  (count_mode_reg == MODE_FALL && fall) ||
                                  (count_mode_reg == MODE_BOTH && (rise || fall));
                    end
                end
                pins_next = item.capture_pins;

                // Advance and apply match actions
                if (advance)
                begin
                    count_next = count_inc;
                    for (int ch = 0; ch < NUM_MATCH; ch++)
                    begin
                        if (match_reg[ch] == DATA_W'(count_inc))
                        begin
                            ctl = mcr_reg[ch*3 +: 3];
                            act = emr_reg[ch*2 + 4 +: 2];
                            if (ctl[0])
                                flags_next[ch] = 1'b1;
                            if (ctl[1])
                                do_reset = 1'b1;
                            if (ctl[2])
                                do_stop = 1'b1;
                            case (act)
                                EM_CLEAR:  emr_next[ch] = 1'b0;
                                EM_SET:    emr_next[ch] = 1'b1;
                                EM_TOGGLE: emr_next[ch] = !emr_reg[ch];
                                default:   ;
                            endcase
                        end
                    end
                    if (do_reset)
                    begin
                        count_next   = '0;
                        pscount_next = '0;
                    end
                    if (do_stop)
                        run_next = 1'b0;
                end
            end

            OP_WRITE:
            begin
                case (item.reg_index)
                    REG_IR:  flags_next = flags_reg & ~item.write_data[5:0] & FLAG_MASK;
                    REG_TCR:
                    begin
                        run_next = item.write_data[0];
                        if (item.write_data[1])
                        begin
                            count_next   = '0;
                            pscount_next = '0;
                        end
                    end
                    REG_TC:  count_next   = item.write_data[COUNT_WIDTH-1:0];
                    REG_PC:  pscount_next = item.write_data;
                    REG_MCR: mcr_next     = item.write_data[11:0] & MCR_MASK;
                    REG_EMR: emr_next     = item.write_data[11:0] & EMR_MASK;
                    default: ;
                endcase
                for (int i = 0; i < NUM_MATCH; i++)
                begin
                    if (item.reg_index == REG_MATCH0 + 4'(i))
                        match_next[i] = item.write_data;
                end
                for (int i = 0; i < NUM_CAPTURE; i++)
                begin
                    if (item.reg_index == REG_CAP0 + 4'(i))
                        capture_next[i] = item.write_data;
                end
            end

            OP_READ:
            begin
                case (item.reg_index)
                    REG_IR:  result.read_data = DATA_W'(flags_reg);
                    REG_TCR: result.read_data = DATA_W'(run_reg);
                    REG_TC:  result.read_data = DATA_W'(count_reg);
                    REG_PC:  result.read_data = pscount_reg;
                    REG_MCR: result.read_data = DATA_W'(mcr_reg);
                    REG_EMR: result.read_data = DATA_W'(emr_reg);
                    default: ;
                endcase
                for (int i = 0; i < NUM_MATCH; i++)
                begin
                    if (item.reg_index == REG_MATCH0 + 4'(i))
                        result.read_data = match_reg[i];
                end
                for (int i = 0; i < NUM_CAPTURE; i++)
                begin
                    if (item.reg_index == REG_CAP0 + 4'(i))
                        result.read_data = capture_reg[i];
                end
            end

            default: ;
        endcase

        result.irq        = |(flags_next & FLAG_MASK);
        result.match_pins = emr_next[3:0] & PIN_MASK;
    end

    // State registers, updated once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pscount_reg <= '0;
            run_reg     <= 1'b0;
            flags_reg   <= '0;
            mcr_reg     <= '0;
            emr_reg     <= '0;
            pins_reg    <= '0;
            for (int i = 0; i < NUM_MATCH; i++)
                match_reg[i] <= '0;
            for (int i = 0; i < NUM_CAPTURE; i++)
                capture_reg[i] <= '0;
        end
        else if (step_en)
        begin
            count_reg   <= count_next;
            pscount_reg <= pscount_next;
            run_reg     <= run_next;
            flags_reg   <= flags_next;
            mcr_reg     <= mcr_next;
            emr_reg     <= emr_next;
            pins_reg    <= pins_next;
            match_reg   <= match_next;
            capture_reg <= capture_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mct_check.sv */
// Port-level assertions for the match/capture timer, bound to the top level.
`default_nettype none

module mct_check
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // Hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A new result follows an accepted transaction through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transaction");

    // An empty result stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result stage");

    // Leave reset with no result pending
    assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result pending right after reset");

endmodule

bind match_capture_timer mct_check u_mct_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
